// ===== sv/double_to_int_round_modes_unit_macros.svh =====
// assertion macros for the float to integer conversion unit
`ifndef DOUBLE_TO_INT_ROUND_MODES_UNIT_MACROS_SVH
`define DOUBLE_TO_INT_ROUND_MODES_UNIT_MACROS_SVH
// implication checked on every rising clock edge outside reset
`define D2I_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication checked outside reset
`define D2I_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ===== sv/d2i_pkg.sv =====
// shared types and constants of the float to integer conversion unit
package d2i_pkg;
  typedef enum logic [1:0] {
    MODE_AWAY    = 2'd0,
    MODE_TOWARD  = 2'd1,
    MODE_NEAREST = 2'd2,
    MODE_SPARE   = 2'd3
  } mode_t;
  localparam logic [10:0] EXP_SPECIAL = 11'h7ff;
  localparam logic [10:0] EXP_BIAS_INT = 11'd1075;
  localparam logic [63:0] SAT_POS = 64'h7fff_ffff_ffff_ffff;
  localparam logic [63:0] SAT_NEG = 64'h8000_0000_0000_0000;
endpackage

// ===== sv/double_to_int_round_modes_unit.sv =====
// float64 to int64 conversion pipeline with selectable rounding
//
// Usage: one input channel (in_valid/in_stall, fields in_value_bits,
// in_opcode, in_even_only) and one result channel (out_valid/out_stall,
// fields out_rounded, out_overflow). A beat is taken when valid is high
// and stall is low.
// Beats pass through the stages in order; one beat can enter every cycle
// while in_stall is low. Stage 1 decodes and aligns the mantissa, stage 2
// compares the remainder and picks the rounding increment, stage 3 adds
// and applies the even rule, stage 4 applies the sign and saturates.
// A stall on the result side holds the last stage; earlier stages keep
// moving into empty slots, so bubbles are squeezed out. The input side
// is stalled only when every stage is full and the receiver stalls.
// Nothing is lost or repeated.
// Reset (rst_n low, synchronous) clears all valid bits; payload
// registers are not reset. Codes 3 of opcode act as nearest, ties even.
`include "double_to_int_round_modes_unit_macros.svh"
module double_to_int_round_modes_unit import d2i_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_value_bits,
  input  logic [1:0]         in_opcode,
  input  logic               in_even_only,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [63:0] out_rounded,
  output logic               out_overflow
);
  // stage valid bits and advance enables
  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;
  assign en4 = !v4_r || !out_stall;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;
  assign in_stall = !en1;

  // stage 1: decode and align
  logic        neg1_r, even1_r, sat1_r, nan1_r, frac1_r;
  logic [1:0]  mode1_r;
  logic [63:0] ip1_r;
  logic [63:0] rem1_r;
  logic        neg_d, sat_d, nan_d, frac_d;
  logic [10:0] ex_d;
  logic [51:0] fr_d;
  logic [52:0] mant_d;
  logic [63:0] ip_d;
  logic [116:0] wide_d;
  logic [63:0] rem_d;
  logic [10:0] s_d, e_d;
  always_comb begin
    neg_d = in_value_bits[63];
    ex_d = in_value_bits[62:52];
    fr_d = in_value_bits[51:0];
    mant_d = {1'b1, fr_d};
    sat_d = 1'b0; nan_d = 1'b0; frac_d = 1'b0;
    ip_d = '0; wide_d = '0; rem_d = '0; s_d = '0; e_d = '0;
    if (ex_d == EXP_SPECIAL) begin
      sat_d = 1'b1;
      nan_d = (fr_d != '0);
    end else if (ex_d == '0) begin
      frac_d = (fr_d != '0);
    end else if (ex_d >= EXP_BIAS_INT) begin
      e_d = ex_d - EXP_BIAS_INT;
      if (e_d >= 11'd12 || (e_d == 11'd11 && fr_d != '0)) sat_d = 1'b1;
      else ip_d = {11'd0, mant_d} << e_d[3:0];
    end else begin
      s_d = EXP_BIAS_INT - ex_d;
      if (s_d >= 11'd64) begin
        frac_d = 1'b1;
      end else begin
        // shift mantissa into 53 integer bits and 64 fraction bits
        wide_d = {64'd0, mant_d} << (7'd64 - {1'b0, s_d[5:0]});
        ip_d = {11'd0, wide_d[116:64]};
        rem_d = wide_d[63:0];
      end
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v1_r <= 1'b0;
    else if (en1) v1_r <= in_valid;
    if (en1) begin
      neg1_r <= neg_d; even1_r <= in_even_only; mode1_r <= in_opcode;
      sat1_r <= sat_d; nan1_r <= nan_d; frac1_r <= frac_d;
      rem1_r <= rem_d; ip1_r <= ip_d;
    end
  end

  // stage 2: compare remainder against one half and choose increment
  logic        neg2_r, even2_r, sat2_r, nan2_r, up2_r;
  logic [1:0]  mode2_r;
  logic [63:0] ip2_r;
  logic        up_d, frac2_d, gt2_d, eq2_d;
  always_comb begin
    frac2_d = frac1_r || (rem1_r != '0);
    gt2_d = rem1_r[63] && (rem1_r[62:0] != '0);
    eq2_d = rem1_r[63] && (rem1_r[62:0] == '0);
    case (mode_t'(mode1_r))
      MODE_AWAY:   up_d = frac2_d;
      MODE_TOWARD: up_d = 1'b0;
      default:     up_d = gt2_d || (eq2_d && ip1_r[0]);
    endcase
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v2_r <= 1'b0;
    else if (en2) v2_r <= v1_r;
    if (en2) begin
      neg2_r <= neg1_r; even2_r <= even1_r; mode2_r <= mode1_r;
      sat2_r <= sat1_r; nan2_r <= nan1_r; up2_r <= up_d; ip2_r <= ip1_r;
    end
  end

  // stage 3: add increment and apply even rule
  logic        neg3_r, sat3_r, nan3_r;
  logic [64:0] v3m_r;
  logic [64:0] vr_d, vf_d;
  always_comb begin
    vr_d = {1'b0, ip2_r} + {64'd0, up2_r};
    vf_d = vr_d;
    if (even2_r && vr_d[0]) begin
      case (mode_t'(mode2_r))
        MODE_AWAY:   vf_d = vr_d + 65'd1;
        MODE_TOWARD: vf_d = vr_d - 65'd1;
        default:     vf_d = up2_r ? vr_d - 65'd1 : vr_d + 65'd1;
      endcase
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v3_r <= 1'b0;
    else if (en3) v3_r <= v2_r;
    if (en3) begin
      neg3_r <= neg2_r; sat3_r <= sat2_r; nan3_r <= nan2_r; v3m_r <= vf_d;
    end
  end

  // stage 4: sign and saturation
  logic [63:0] res4_r;
  logic        ovf4_r;
  logic [63:0] res_d;
  logic        ovf_d;
  always_comb begin
    ovf_d = 1'b0;
    if (nan3_r) begin
      res_d = SAT_POS; ovf_d = 1'b1;
    end else if (sat3_r) begin
      res_d = neg3_r ? SAT_NEG : SAT_POS; ovf_d = 1'b1;
    end else if (!neg3_r) begin
      if (v3m_r > {1'b0, SAT_POS}) begin res_d = SAT_POS; ovf_d = 1'b1; end
      else res_d = v3m_r[63:0];
    end else begin
      if (v3m_r > {1'b0, SAT_NEG}) begin res_d = SAT_NEG; ovf_d = 1'b1; end
      else res_d = 64'd0 - v3m_r[63:0];
    end
  end
  always_ff @(posedge clk) begin
    if (!rst_n) v4_r <= 1'b0;
    else if (en4) v4_r <= v3_r;
    if (en4) begin
      res4_r <= res_d; ovf4_r <= ovf_d;
    end
  end
  assign out_valid = v4_r;
  assign out_rounded = res4_r;
  assign out_overflow = ovf4_r;

  // checks
  `D2I_ASSERT_NEXT(a_hold_on_stall, out_valid && out_stall,
    out_valid && $stable(out_rounded), "result changed under stall")
  `D2I_ASSERT_IMP(a_no_in_stall_when_empty, !v4_r, !in_stall,
    "input stalled with empty output stage")
  `D2I_ASSERT_IMP(a_nan_saturates, v3_r && nan3_r,
    res_d == SAT_POS && ovf_d, "nan did not saturate positive")
  `D2I_ASSERT_IMP(a_pos_in_range, v3_r && !sat3_r && !neg3_r && !ovf_d,
    !res_d[63], "positive result has sign bit set")
endmodule
